// File: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define PPG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/ppg_pkg.sv
`default_nettype none

package ppg_pkg;

  // Item and register widths
  localparam int PHASE_W    = 14;
  localparam int COORD_W    = 3;
  localparam int TS_W       = 10;
  localparam int SCALE_W    = 12;
  localparam int SHIFT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int COLOR_W    = 24;
  localparam int ANG_W      = 10;

  localparam logic [PHASE_W:0] PHASE_WRAP = 15'd10240;

  // Grid is a power of two, so the coordinate divide is a shift
  localparam int GRID_SHIFT = 3;

  // Input function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SHIFT   = 2'd2;

  localparam logic [TS_W-1:0]    TIME_STEP_RST     = 10'd16;
  localparam logic [SCALE_W-1:0] SPATIAL_SCALE_RST = 12'd1024;
  localparam logic [SHIFT_W-1:0] COLOR_SHIFT_RST   = 8'd0;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Reciprocal multipliers: floor(7p/10), floor(13p/10) as (p*M) >> 21
  localparam logic [20:0] T07_MUL = 21'd1468012;
  localparam logic [21:0] T13_MUL = 22'd2726308;
  localparam int          T1X_SHIFT = 21;
  // floor(n/5110) as (n*M) >> 33 for n below 2^21
  localparam logic [20:0] LEVEL_MUL = 21'd1681005;
  localparam int          LEVEL_SHIFT = 33;

  // CORDIC and root
  localparam int CORDIC_STEPS = 14;
  localparam int SQRT_STEPS   = 13;
  localparam int CW           = 27;
  localparam int ZW           = 18;
  localparam int RW           = 26;
  localparam logic [13:0] ATAN_STEP [CORDIC_STEPS] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
    14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
  };

  // Sine over one turn of 1024 steps, stored as a quarter wave
  localparam int SINE_DEPTH   = 1024;
  localparam int SINE_QSHIFT  = 8;
  localparam int SINE_QUARTER = SINE_DEPTH / 4;
  typedef logic [8:0] qsine_tab_t [SINE_QUARTER];

  // Magnitude round(511 * sin(2*pi*r/1024)) from a Taylor series in Q30
  function automatic logic [8:0] sine_mag(int r);
    longint unsigned x, x2, t, s, mag, one, hpi;
    one = 64'd1073741824;
    hpi = 64'd1686629713;
    x = (64'(r) * hpi) >> SINE_QSHIFT;
    x2 = (x * x) >> 30;
    t = one - x2 / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    mag = (s * 511 + (one >> 1)) >> 30;
    return 9'(mag);
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int k = 0; k < SINE_QUARTER; k++) begin
      tab[k] = sine_mag(k);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_LUT = build_qsine();
  localparam logic [8:0] SINE_PEAK = sine_mag(SINE_QUARTER);

  // Mirror odd quarters, negate the second half turn
  function automatic logic signed [9:0] sine_of(logic [ANG_W-1:0] a);
    logic [8:0] mag;
    if (!a[8]) begin
      mag = QSINE_LUT[a[7:0]];
    end else if (a[7:0] == 8'd0) begin
      mag = SINE_PEAK;
    end else begin
      mag = QSINE_LUT[8'd0 - a[7:0]];
    end
    return a[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Pixel word handed from front to back
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } ppg_word_t;

  typedef struct packed {
    logic      valid;
    ppg_word_t word;
  } ppg_push_t;

endpackage

`default_nettype wire

// File: src/ppg_front.sv
`default_nettype none

module ppg_front import ppg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic [COORD_W-1:0] pixel_x_i,
  input  wire logic [COORD_W-1:0] pixel_y_i,
  input  wire logic [TS_W-1:0]    time_step_i,
  input  wire logic               q_full_i,
  output ppg_push_t               push_o
);

  logic               accept;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W:0]   phase_sum;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Advance the frame phase on a tick, wrapping at ten turns
  always_comb begin
    phase_sum = {1'b0, phase_q} + {5'b0, time_step_i};
    phase_d   = phase_q;
    if (accept && func_i == FUNC_TICK) begin
      if (phase_sum >= PHASE_WRAP) begin
        phase_d = PHASE_W'(phase_sum - PHASE_WRAP);
      end else begin
        phase_d = phase_sum[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Hand pixel words to the queue with the phase of their time
  always_comb begin
    push_o.valid      = accept && func_i == FUNC_PIXEL;
    push_o.word.phase = phase_q;
    push_o.word.x     = pixel_x_i;
    push_o.word.y     = pixel_y_i;
  end

endmodule

`default_nettype wire

// File: src/ppg_queue.sv
`default_nettype none

module ppg_queue import ppg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ppg_push_t  push_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output ppg_word_t       word_o
);

  ppg_word_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign word_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.word;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)       rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i.valid && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i.valid && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/ppg_back.sv
`default_nettype none

module ppg_back import ppg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire ppg_word_t          in_word_i,
  output logic                    in_ready_o,
  input  wire logic [SCALE_W-1:0] scale_i,
  input  wire logic [SHIFT_W-1:0] shift_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [COLOR_W-1:0]      color_o
);

  localparam logic [2:0] SECT_RY = 3'd0;
  localparam logic [2:0] SECT_YG = 3'd1;
  localparam logic [2:0] SECT_GC = 3'd2;
  localparam logic [2:0] SECT_CB = 3'd3;
  localparam logic [2:0] SECT_BM = 3'd4;

  logic adv;

  // Whole pipeline moves together; the output register holds on stall
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_ready_o = adv;

  // ---------------- stage A: coordinates and phase multiples
  logic                     a_v_q;
  logic [SCALE_W-1:0]       a_nx_q, a_ny_q;
  logic signed [12:0]       a_cx_q, a_cy_q;
  logic [ANG_W-1:0]         a_t07_q, a_t13_q, a_t15_q, a_p_q;
  logic [14:0]              nx_prod, ny_prod;
  logic [SCALE_W-1:0]       nx_d, ny_d;
  logic [10:0]              half;
  logic [34:0]              t07_prod, t13_prod;
  logic [15:0]              p3;

  always_comb begin
    nx_prod  = 15'(in_word_i.x) * 15'(scale_i);
    ny_prod  = 15'(in_word_i.y) * 15'(scale_i);
    nx_d     = nx_prod[14:GRID_SHIFT];
    ny_d     = ny_prod[14:GRID_SHIFT];
    half     = scale_i[SCALE_W-1:1];
    t07_prod = 35'(in_word_i.phase) * 35'(T07_MUL);
    t13_prod = 35'(in_word_i.phase) * 35'(T13_MUL);
    p3       = 16'(in_word_i.phase) * 16'd3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (adv) a_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_nx_q  <= nx_d;
      a_ny_q  <= ny_d;
      a_cx_q  <= $signed({1'b0, nx_d}) - $signed({2'b00, half});
      a_cy_q  <= $signed({1'b0, ny_d}) - $signed({2'b00, half});
      a_t07_q <= t07_prod[T1X_SHIFT+ANG_W-1:T1X_SHIFT];
      a_t13_q <= t13_prod[T1X_SHIFT+ANG_W-1:T1X_SHIFT];
      a_t15_q <= p3[ANG_W:1];
      a_p_q   <= in_word_i.phase[ANG_W-1:0];
    end
  end

  // ---------------- stage B: squares, CORDIC prerotation, plain wave angles
  logic signed [25:0] sq_x, sq_y;
  logic signed [CW-1:0] xs, ys, xr, yr;
  logic signed [ZW-1:0] zr;

  logic                 c_v_q    [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_x_q    [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_y_q    [CORDIC_STEPS+1];
  logic signed [ZW-1:0] c_z_q    [CORDIC_STEPS+1];
  logic [RW-1:0]        c_rem_q  [CORDIC_STEPS+1];
  logic [RW-1:0]        c_root_q [CORDIC_STEPS+1];
  logic                 c_zero_q [CORDIC_STEPS+1];
  logic [ANG_W-1:0]     c_w0_q   [CORDIC_STEPS+1];
  logic [ANG_W-1:0]     c_w1_q   [CORDIC_STEPS+1];
  logic [ANG_W-1:0]     c_w2_q   [CORDIC_STEPS+1];
  logic [ANG_W-1:0]     c_t15_q  [CORDIC_STEPS+1];
  logic [ANG_W-1:0]     c_p_q    [CORDIC_STEPS+1];

  always_comb begin
    sq_x = a_cx_q * a_cx_q;
    sq_y = a_cy_q * a_cy_q;
    xs = {{(CW-23){a_cx_q[12]}}, a_cx_q, 10'b0};
    ys = {{(CW-23){a_cy_q[12]}}, a_cy_q, 10'b0};
    xr = xs;
    yr = ys;
    zr = '0;
    // Rotate the left half plane by a quarter turn
    if (xs < 0) begin
      if (ys >= 0) begin
        xr = ys;
        yr = -xs;
        zr = ZW'(16384);
      end else begin
        xr = -ys;
        yr = xs;
        zr = -ZW'(16384);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q[0] <= 1'b0;
    else if (adv) c_v_q[0] <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_x_q[0]    <= xr;
      c_y_q[0]    <= yr;
      c_z_q[0]    <= zr;
      c_rem_q[0]  <= RW'($unsigned(sq_x)) + RW'($unsigned(sq_y));
      c_root_q[0] <= '0;
      c_zero_q[0] <= (a_cx_q == '0) && (a_cy_q == '0);
      c_w0_q[0]   <= a_nx_q[ANG_W-1:0] + a_p_q;
      c_w1_q[0]   <= a_ny_q[ANG_W-1:0] + a_t07_q;
      c_w2_q[0]   <= a_nx_q[ANG_W-1:0] + a_ny_q[ANG_W-1:0] + a_t13_q;
      c_t15_q[0]  <= a_t15_q;
      c_p_q[0]    <= a_p_q;
    end
  end

  // ---------------- CORDIC and square root, one step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy, x_d, y_d;
    logic signed [ZW-1:0] z_d;
    logic [RW:0]          trial;
    logic [RW-1:0]        rem_d, root_d;

    always_comb begin
      dx = c_y_q[i] >>> i;
      dy = c_x_q[i] >>> i;
      if (c_y_q[i] > 0) begin
        x_d = c_x_q[i] + dx;
        y_d = c_y_q[i] - dy;
        z_d = c_z_q[i] + $signed({4'b0, ATAN_STEP[i]});
      end else begin
        x_d = c_x_q[i] - dx;
        y_d = c_y_q[i] + dy;
        z_d = c_z_q[i] - $signed({4'b0, ATAN_STEP[i]});
      end
      trial  = '0;
      rem_d  = c_rem_q[i];
      root_d = c_root_q[i];
      if (i < SQRT_STEPS) begin
        trial = {1'b0, c_root_q[i]} + ((RW+1)'(1) << (2 * (SQRT_STEPS - 1 - i)));
        if ({1'b0, c_rem_q[i]} >= trial) begin
          rem_d  = RW'({1'b0, c_rem_q[i]} - trial);
          root_d = (c_root_q[i] >> 1) + (RW'(1) << (2 * (SQRT_STEPS - 1 - i)));
        end else begin
          root_d = c_root_q[i] >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) c_v_q[i+1] <= 1'b0;
      else if (adv) c_v_q[i+1] <= c_v_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_x_q[i+1]    <= x_d;
        c_y_q[i+1]    <= y_d;
        c_z_q[i+1]    <= z_d;
        c_rem_q[i+1]  <= rem_d;
        c_root_q[i+1] <= root_d;
        c_zero_q[i+1] <= c_zero_q[i];
        c_w0_q[i+1]   <= c_w0_q[i];
        c_w1_q[i+1]   <= c_w1_q[i];
        c_w2_q[i+1]   <= c_w2_q[i];
        c_t15_q[i+1]  <= c_t15_q[i];
        c_p_q[i+1]    <= c_p_q[i];
      end
    end
  end

  // ---------------- stage D: angle rounding, radial and spiral angles
  logic [ZW-1:0]    z_rnd;
  logic [ANG_W-1:0] ang, dist2;
  logic             d_v_q;
  logic [ANG_W-1:0] d_w_q [5];

  always_comb begin
    z_rnd = $unsigned(c_z_q[CORDIC_STEPS] + ZW'(32));
    ang   = c_zero_q[CORDIC_STEPS] ? '0 : z_rnd[ANG_W+5:6];
    dist2 = {c_root_q[CORDIC_STEPS][ANG_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else if (adv) d_v_q <= c_v_q[CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_w_q[0] <= c_w0_q[CORDIC_STEPS];
      d_w_q[1] <= c_w1_q[CORDIC_STEPS];
      d_w_q[2] <= c_w2_q[CORDIC_STEPS];
      d_w_q[3] <= dist2 - c_t15_q[CORDIC_STEPS];
      d_w_q[4] <= {ang[ANG_W-2:0], 1'b0} + ang + dist2 + c_p_q[CORDIC_STEPS];
    end
  end

  // ---------------- stage E: sine lookups from the quarter-wave table
  logic              e_v_q;
  logic signed [9:0] e_s_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else if (adv) e_v_q <= d_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 5; k++) begin
        e_s_q[k] <= sine_of(d_w_q[k]);
      end
    end
  end

  // ---------------- stage F: sum and scale by 255
  logic signed [12:0] wsum;
  logic [12:0]        wpos;
  logic               f_v_q;
  logic [20:0]        f_prod_q;

  always_comb begin
    wsum = 13'(e_s_q[0]) + 13'(e_s_q[1]) + 13'(e_s_q[2]) + 13'(e_s_q[3])
         + 13'(e_s_q[4]);
    wpos = $unsigned(wsum + 13'sd2555);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else if (adv) f_v_q <= e_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) f_prod_q <= 21'(wpos) * 21'd255;
  end

  // ---------------- stage G: divide by 5110
  logic [41:0] lvl_prod;
  logic        g_v_q;
  logic [7:0]  g_level_q;

  assign lvl_prod = 42'(f_prod_q) * 42'(LEVEL_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else if (adv) g_v_q <= f_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) g_level_q <= lvl_prod[LEVEL_SHIFT+7:LEVEL_SHIFT];
  end

  // ---------------- stage H: hue wheel into the output register
  logic [11:0] hue_sum;
  logic [10:0] hue;
  logic [2:0]  sector;
  logic [7:0]  ramp, r, g, b;
  logic        out_valid_q;
  logic [COLOR_W-1:0] color_q;

  always_comb begin
    hue_sum = 12'(g_level_q) * 12'd6 + 12'(shift_i) * 12'd6;
    hue     = (hue_sum >= 12'd1536) ? 11'(hue_sum - 12'd1536) : hue_sum[10:0];
    sector  = hue[10:8];
    ramp    = sector[0] ? ~hue[7:0] : hue[7:0];
    case (sector)
      SECT_RY: begin r = 8'hff; g = ramp;  b = 8'h00; end
      SECT_YG: begin r = ramp;  g = 8'hff; b = 8'h00; end
      SECT_GC: begin r = 8'h00; g = 8'hff; b = ramp;  end
      SECT_CB: begin r = 8'h00; g = ramp;  b = 8'hff; end
      SECT_BM: begin r = ramp;  g = 8'h00; b = 8'hff; end
      default: begin r = 8'hff; g = 8'h00; b = ramp;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= g_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) color_q <= {r, g, b};
  end

  assign out_valid_o = out_valid_q;
  assign color_o     = color_q;

endmodule

`default_nettype wire

// File: src/plasma_pixel_generator.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o func_i, pixel_x_i, pixel_y_i
// output    out        out_valid_o/out_stall_i color_o
// config    in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One word is accepted per cycle while in_stall_o is low; ticks and pixels mix freely.
// An accepted pixel word is written into the queue, then passes through the back
// pipeline stages A and B, the 14-step CORDIC with the square root running
// beside it, and stages D to H into the output register.
// Reset clears the frame phase, the queue and all stage valid bits.
// A stall on a valid output word freezes the whole back pipeline; the four-entry queue
// keeps the input side taking words until it fills.
`default_nettype none

module plasma_pixel_generator import ppg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic [COORD_W-1:0]    pixel_x_i,
  input  wire logic [COORD_W-1:0]    pixel_y_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [COLOR_W-1:0]         color_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [TS_W-1:0]    time_step_q;
  logic [SCALE_W-1:0] scale_q;
  logic [SHIFT_W-1:0] shift_q;
  ppg_push_t          push;
  logic               q_full, q_valid, back_ready;
  ppg_word_t          q_word;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      scale_q     <= SPATIAL_SCALE_RST;
      shift_q     <= COLOR_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TIME_STEP:     time_step_q <= cfg_wdata_i[TS_W-1:0];
        REG_SPATIAL_SCALE: scale_q     <= cfg_wdata_i[SCALE_W-1:0];
        REG_COLOR_SHIFT:   shift_q     <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  ppg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .time_step_i (time_step_q),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  ppg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (back_ready),
    .valid_o (q_valid),
    .word_o  (q_word)
  );

  ppg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_word_i   (q_word),
    .in_ready_o  (back_ready),
    .scale_i     (scale_q),
    .shift_i     (shift_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .color_o     (color_o)
  );

`include "assert_macros.svh"

  `PPG_ASSERT(a_push_only_pixel, push.valid |-> (in_valid_i && !in_stall_o && func_i == FUNC_PIXEL), "queue push without an accepted pixel word")
  `PPG_ASSERT(a_no_overflow, !(push.valid && q_full), "push into a full queue")
  `PPG_ASSERT(a_stall_freezes, (out_valid_o && out_stall_i) |-> !back_ready, "back pipeline moves while output is stalled")

endmodule

`default_nettype wire

// File: dv/ppg_checker.sv
`timescale 1ns / 1ps

module ppg_checker import ppg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  func_i,
  input  logic [COORD_W-1:0]    pixel_x_i,
  input  logic [COORD_W-1:0]    pixel_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [COLOR_W-1:0]    color_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    errors_o,
  output int                    pending_o
);

  logic [TS_W-1:0]    step_q;
  logic [SCALE_W-1:0] scale_q;
  logic [SHIFT_W-1:0] shift_q;
  int                 phase_q;
  logic [COLOR_W-1:0] colors_due [$];

  // Table value: round(511 * sin(2*pi*k/1024)) from a Taylor series in Q30
  function automatic int sine_at(int ang);
    longint unsigned q, r, x, x2, t, s, mag;
    int k, quad;
    k = ang & 1023;
    q = 256;
    quad = (k / 256) & 3;
    r = longint'(k % 256);
    if ((quad & 1) != 0) r = q - r;
    x = r * 64'd1686629713 / q;
    x2 = (x * x) >> 30;
    t = 64'd1073741824 - x2 / 72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    mag = (s * 511 + 64'd536870912) >> 30;
    return ((quad & 2) != 0) ? -int'(mag) : int'(mag);
  endfunction

  function automatic int root_floor(int unsigned v);
    int unsigned root, b;
    root = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return int'(root);
  endfunction

  // Angle around the center in 1/1024 turn, via 14 CORDIC rotations
  function automatic int angle_turns(int y, int x);
    int z, nx, dx, dy;
    int steps [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    int unsigned zu;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 1024;
    y = y * 1024;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; x = nx; z = 16384;
      end else begin
        nx = -y; y = x; x = nx; z = -16384;
      end
    end
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + steps[i];
      end else begin
        x = x - dx; y = y + dy; z = z - steps[i];
      end
    end
    zu = int'(z + 131072);
    return int'(((zu + 32) >> 6) & 1023);
  endfunction

  function automatic logic [COLOR_W-1:0] plasma_color(int px, int py);
    int p, t07, t13, t15, nx, ny, half, cx, cy, radius, ang, sum;
    int level, hue, f, ramp, r, g, b;
    p = phase_q;
    t07 = p * 7 / 10;
    t13 = p * 13 / 10;
    t15 = p * 3 / 2;
    nx = px * int'(scale_q) / 8;
    ny = py * int'(scale_q) / 8;
    half = int'(scale_q) / 2;
    cx = nx - half;
    cy = ny - half;
    radius = root_floor(cx * cx + cy * cy);
    ang = angle_turns(cy, cx);
    sum = sine_at(nx + p) + sine_at(ny + t07) + sine_at(nx + ny + t13)
        + sine_at(2 * radius - t15) + sine_at(3 * ang + 2 * radius + p);
    level = (sum + 2555) * 255 / 5110;
    hue = (level * 6 + int'(shift_q) * 6) % 1536;
    f = hue & 255;
    ramp = ((hue >> 8) & 1) != 0 ? 255 - f : f;
    case (hue >> 8)
      0: begin r = 255; g = ramp; b = 0; end
      1: begin r = ramp; g = 255; b = 0; end
      2: begin r = 0; g = 255; b = ramp; end
      3: begin r = 0; g = ramp; b = 255; end
      4: begin r = ramp; g = 0; b = 255; end
      default: begin r = 255; g = 0; b = ramp; end
    endcase
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  assign pending_o = colors_due.size();

  // Track registers and phase, predict on each accepted pixel word, compare each result word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= TIME_STEP_RST;
      scale_q  <= SPATIAL_SCALE_RST;
      shift_q  <= COLOR_SHIFT_RST;
      phase_q  = 0;
      errors_o <= 0;
      colors_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TIME_STEP:     step_q  <= cfg_wdata_i[TS_W-1:0];
          REG_SPATIAL_SCALE: scale_q <= cfg_wdata_i[SCALE_W-1:0];
          REG_COLOR_SHIFT:   shift_q <= cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == FUNC_TICK) phase_q = (phase_q + int'(step_q)) % 10240;
        else colors_due.push_back(plasma_color(int'(pixel_x_i), int'(pixel_y_i)));
      end
      if (out_valid_i && !out_stall_i) begin
        if (colors_due.size() == 0) begin
          if (errors_o < 10) $display("unexpected color word %06h", color_i);
          errors_o <= errors_o + 1;
        end else begin
          if (color_i !== colors_due[0]) begin
            if (errors_o < 10)
              $display("color mismatch: expected %06h, got %06h", colors_due[0], color_i);
            errors_o <= errors_o + 1;
          end
          void'(colors_due.pop_front());
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ppg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  func_i = FUNC_TICK;
  logic [COORD_W-1:0]    pixel_x_i = '0;
  logic [COORD_W-1:0]    pixel_y_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COLOR_W-1:0]    color_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int                    errors;
  int                    pending;
  bit                    stall_quiet = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  plasma_pixel_generator u_top (.*);

  ppg_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .pixel_x_i,
    .pixel_y_i, .out_valid_i(out_valid_o), .out_stall_i, .color_i(color_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(logic f, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= f;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // Drain, let trailing ticks settle, then load a new setting
  task automatic load_setting(int ts, int sc, int cs);
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    write_reg(REG_TIME_STEP, CFG_DATA_W'(ts));
    write_reg(REG_SPATIAL_SCALE, CFG_DATA_W'(sc));
    write_reg(REG_COLOR_SHIFT, CFG_DATA_W'(cs));
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  // Mostly pixels with random coordinates, a quarter ticks
  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_word(FUNC_TICK, 3'($urandom), 3'($urandom));
      else send_word(FUNC_PIXEL, 3'($urandom), 3'($urandom));
    end
  endtask

  // Output stall: bursts of random length, with quiet stretches
  initial begin
    int run;
    forever begin
      run = gap_len();
      repeat (run) @(negedge clk_i) out_stall_i <= !stall_quiet;
      run = $urandom_range(1, 12);
      repeat (run) @(negedge clk_i) out_stall_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        stall_quiet = 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
        stall_quiet = 1'b0;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("plasma_pixel_generator regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: corners, center, ticks at reset setting
    send_word(FUNC_PIXEL, 3'd0, 3'd0);
    send_word(FUNC_PIXEL, 3'd7, 3'd7);
    send_word(FUNC_PIXEL, 3'd0, 3'd7);
    send_word(FUNC_PIXEL, 3'd7, 3'd0);
    send_word(FUNC_PIXEL, 3'd4, 3'd4);
    send_word(FUNC_TICK, 3'd7, 3'd7);
    send_word(FUNC_PIXEL, 3'd4, 3'd4);
    send_word(FUNC_PIXEL, 3'd4, 3'd0);
    send_word(FUNC_PIXEL, 3'd0, 3'd4);
    send_word(FUNC_TICK, 3'd0, 3'd0);
    send_word(FUNC_PIXEL, 3'd3, 3'd5);
    load_setting(1023, 4095, 255);
    for (int i = 0; i < 12; i++) send_word(FUNC_TICK, 3'd0, 3'd0);
    send_word(FUNC_PIXEL, 3'd7, 3'd7);
    send_word(FUNC_PIXEL, 3'd0, 3'd0);
    random_words(90);
    load_setting(0, 0, 0);
    send_word(FUNC_TICK, 3'd1, 3'd2);
    random_words(80);
    load_setting(1, 1, 1);
    random_words(80);
    for (int s = 0; s < 3; s++) begin
      load_setting($urandom_range(0, 1023), $urandom_range(0, 4095), $urandom_range(0, 255));
      random_words(100);
    end
    load_setting(16, 1024, 128);
    random_words(90);

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("plasma_pixel_generator regression: pass");
    end else begin
      $display("plasma_pixel_generator regression: fail");
    end
    $finish;
  end

endmodule
